[rtl/digit_text_to_byte_converter_defines.svh]
// assertion macros for the converter rtl, included by dtb_step
`ifndef DIGIT_TEXT_TO_BYTE_CONVERTER_DEFINES_SVH
`define DIGIT_TEXT_TO_BYTE_CONVERTER_DEFINES_SVH

// plain property, checked on every clock edge out of reset
`define DTB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// next-cycle implication, checked out of reset
`define DTB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/dtb_pkg.sv]
// types and character constants for the digit text to byte converter
package dtb_pkg;

  // radix mode register codes; other codes emit nothing and flag every character
  typedef enum logic [2:0] {
    MODE_HEX  = 3'd0,
    MODE_DEC  = 3'd1,
    MODE_OCT  = 3'd2,
    MODE_BIN  = 3'd3,
    MODE_TEXT = 3'd4
  } radix_mode_e;

  // character codes
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_1     = 8'h31;
  localparam logic [7:0] CHAR_7     = 8'h37;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;

  // digits per byte in each radix
  localparam logic [3:0] GROUP_HEX = 4'd2;
  localparam logic [3:0] GROUP_DEC = 4'd3;
  localparam logic [3:0] GROUP_OCT = 4'd3;
  localparam logic [3:0] GROUP_BIN = 4'd8;

  localparam int unsigned CountW = 3;
  localparam int unsigned AccW   = 10;

  // one input character beat
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } dtb_char_t;

  // one result beat
  typedef struct packed {
    logic [7:0] byte_value;
    logic       byte_ready;
    logic       char_invalid;
    logic       run_end;
  } dtb_result_t;

endpackage

[rtl/dtb_if.sv]
// channel interfaces: character input, byte output, mode register write
interface dtb_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface dtb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       byte_ready;
  logic       char_invalid;
  logic       run_end;

  modport source (output valid, output byte_value, output byte_ready,
                  output char_invalid, output run_end, input ready);
  modport sink   (input valid, input byte_value, input byte_ready,
                  input char_invalid, input run_end, output ready);
endinterface

interface dtb_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] radix_mode;

  modport source (output valid, output radix_mode, input ready);
  modport sink   (input valid, input radix_mode, output ready);
endinterface

[rtl/digit_text_to_byte_converter.sv]
// top level of the digit text to byte converter
//
//  channel  | dir | payload                                       | handshake
//  char_i   | in  | char_code[7:0], last_char                     | valid/ready
//  byte_o   | out | byte_value[7:0], byte_ready, char_invalid,    | valid/ready
//           |     | run_end                                       |
//  cfg_i    | in  | radix_mode[2:0]                               | valid/ready
//
// one character per cycle while the output is not stalled; each beat passes the input
// register, then decode and accumulate into the output register, which offers the
// result for that beat
// the group accumulator updates in the same cycle a beat moves to the output stage
// reset clears the mode to hex and empties the group and both stages
// a stalled output holds its beat; the input stage still takes one more beat if it is empty
module digit_text_to_byte_converter (
  input logic       clk_i,
  input logic       rst_ni,
  dtb_char_if.sink  char_i,
  dtb_byte_if.source byte_o,
  dtb_cfg_if.sink   cfg_i
);
  import dtb_pkg::*;

  radix_mode_e mode_q;
  dtb_char_t   in_char, held_char;
  dtb_result_t step_res, out_res;
  logic        held_valid, out_free, fire;

  // mode register, always writable
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_HEX;
    end else if (cfg_i.valid) begin
      mode_q <= radix_mode_e'(cfg_i.radix_mode);
    end
  end

  assign in_char.char_code = char_i.char_code;
  assign in_char.last_char = char_i.last_char;

  // input stage
  dtb_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (char_i.valid),
    .ready_o (char_i.ready),
    .char_i  (in_char),
    .valid_o (held_valid),
    .take_i  (fire),
    .char_o  (held_char)
  );

  // a beat is processed when the output stage can take its result
  assign fire = held_valid && out_free;

  dtb_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .mode_i   (mode_q),
    .char_i   (held_char),
    .result_o (step_res)
  );

  // output stage
  dtb_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (fire),
    .ready_o  (out_free),
    .result_i (step_res),
    .valid_o  (byte_o.valid),
    .ready_i  (byte_o.ready),
    .result_o (out_res)
  );

  assign byte_o.byte_value   = out_res.byte_value;
  assign byte_o.byte_ready   = out_res.byte_ready;
  assign byte_o.char_invalid = out_res.char_invalid;
  assign byte_o.run_end      = out_res.run_end;
endmodule

[rtl/dtb_in_reg.sv]
// input register stage holding one character beat
module dtb_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  dtb_pkg::dtb_char_t char_i,
  output logic              valid_o,
  input  logic              take_i,
  output dtb_pkg::dtb_char_t char_o
);
  import dtb_pkg::*;

  logic      valid_q;
  dtb_char_t char_q;

  // free slot or the held beat leaves this cycle
  assign ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      char_q <= char_i;
    end
  end

  assign valid_o = valid_q;
  assign char_o  = char_q;
endmodule

[rtl/dtb_step.sv]
// digit decode, group accumulator and flush logic for one character
module dtb_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  dtb_pkg::radix_mode_e mode_i,
  input  dtb_pkg::dtb_char_t  char_i,
  output dtb_pkg::dtb_result_t result_o
);
  import dtb_pkg::*;

  `include "digit_text_to_byte_converter_defines.svh"

  logic [CountW-1:0] cnt_q, cnt_d, cnt_inc, cnt_after;
  logic [AccW-1:0]   acc_q, acc_d, acc_next, acc_after, acc_x10;
  logic [7:0]        c;
  logic              is_space, is_dec, is_oct, is_bin, is_lhex, is_uhex;
  logic              take, invalid, text_pass, group_done, flush;
  logic [3:0]        digit, hex_digit, group_size;
  logic [7:0]        done_byte, byte_val;
  logic              byte_rdy;

  assign c = char_i.char_code;

  // character classes
  assign is_space = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  assign is_dec   = (c >= CHAR_0) && (c <= CHAR_9);
  assign is_oct   = (c >= CHAR_0) && (c <= CHAR_7);
  assign is_bin   = (c == CHAR_0) || (c == CHAR_1);
  assign is_lhex  = (c >= CHAR_LA) && (c <= CHAR_LF);
  assign is_uhex  = (c >= CHAR_UA) && (c <= CHAR_UF);
  // letters a-f and A-F have low nibble 1..6
  assign hex_digit = is_dec ? c[3:0] : c[3:0] + 4'd9;
  assign acc_x10   = {acc_q[6:0], 3'b000} + {acc_q[8:0], 1'b0};

  // per-mode decode and accumulator update
  always_comb begin
    take       = 1'b0;
    invalid    = 1'b0;
    text_pass  = 1'b0;
    digit      = c[3:0];
    group_size = GROUP_HEX;
    acc_next   = acc_q;
    unique case (mode_i)
      MODE_HEX: begin
        take       = is_dec || is_lhex || is_uhex;
        invalid    = !take && !is_space;
        digit      = hex_digit;
        group_size = GROUP_HEX;
        acc_next   = {acc_q[5:0], 4'b0000} + {6'd0, hex_digit};
      end
      MODE_DEC: begin
        take       = is_dec;
        invalid    = !take && !is_space;
        group_size = GROUP_DEC;
        acc_next   = acc_x10 + {6'd0, digit};
      end
      MODE_OCT: begin
        take       = is_oct;
        invalid    = !take && !is_space;
        group_size = GROUP_OCT;
        acc_next   = {acc_q[6:0], 3'b000} + {6'd0, digit};
      end
      MODE_BIN: begin
        take       = is_dec;
        invalid    = !(is_bin || is_space);
        digit      = {3'b000, c == CHAR_1};
        group_size = GROUP_BIN;
        acc_next   = {acc_q[8:0], c == CHAR_1};
      end
      MODE_TEXT: begin
        text_pass = 1'b1;
      end
      default: begin
        invalid = 1'b1;
      end
    endcase
  end

  // group completion, with octal top digit clamped to 3
  assign cnt_inc    = cnt_q + CountW'(1);
  assign group_done = take && (({1'b0, cnt_inc} >= group_size) || (cnt_inc == '0));
  assign done_byte  = ((mode_i == MODE_OCT) && (acc_next[9:8] != 2'b00))
                    ? {2'b11, acc_next[5:0]} : acc_next[7:0];

  assign cnt_after = !take ? cnt_q : (group_done ? '0 : cnt_inc);
  assign acc_after = !take ? acc_q : (group_done ? '0 : acc_next);

  // end of string flushes a partial group right-aligned
  assign flush = char_i.last_char && !text_pass && !group_done &&
                 (cnt_after != '0) && (mode_i <= MODE_BIN);

  always_comb begin
    byte_rdy = 1'b1;
    byte_val = 8'd0;
    priority if (text_pass) begin
      byte_val = c;
    end else if (group_done) begin
      byte_val = done_byte;
    end else if (flush) begin
      byte_val = acc_after[7:0];
    end else begin
      byte_rdy = 1'b0;
    end
  end

  assign cnt_d = char_i.last_char ? '0 : cnt_after;
  assign acc_d = char_i.last_char ? '0 : acc_after;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      acc_q <= '0;
    end else if (fire_i) begin
      cnt_q <= cnt_d;
      acc_q <= acc_d;
    end
  end

  assign result_o.byte_value   = byte_val;
  assign result_o.byte_ready   = byte_rdy;
  assign result_o.char_invalid = invalid;
  assign result_o.run_end      = char_i.last_char;

  `DTB_ASSERT(a_idle_byte_zero, result_o.byte_ready || (result_o.byte_value == 8'd0),
              "byte value set without byte ready")
  `DTB_ASSERT_NEXT(a_last_clears, fire_i && char_i.last_char,
                   (cnt_q == '0) && (acc_q == '0), "group state kept past end of string")
  `DTB_ASSERT_NEXT(a_hold_state, !fire_i, $stable(cnt_q) && $stable(acc_q),
                   "group state moved without a beat")
endmodule

[rtl/dtb_out_reg.sv]
// output register stage holding one result beat
module dtb_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  dtb_pkg::dtb_result_t result_i,
  output logic                valid_o,
  input  logic                ready_i,
  output dtb_pkg::dtb_result_t result_o
);
  import dtb_pkg::*;

  logic        valid_q;
  dtb_result_t result_q;

  // slot free or drained this cycle
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;
endmodule
